>>> rtl/assert_macros.svh
// Assertion macros shared by the cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/lea_pkg.sv
`timescale 1ns / 1ps
package lea_pkg;
    localparam int unsigned MAX_ROUNDS_DEF = 32;
    localparam int unsigned KEY_WORD_W = 32;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GROUPS = 3'd5;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_CRYPT,
        ST_DONE
    } lea_state_t;

    // Six round-key words travel together as one store row.
    typedef logic [6*KEY_WORD_W-1:0] lea_rk_row_t;

    function automatic logic [31:0] delta(input logic [2:0] idx);
        logic [31:0] d;
        case (idx)
            3'd0: d = 32'hC3EFE9DB;
            3'd1: d = 32'h44626B02;
            3'd2: d = 32'h79E27C8A;
            3'd3: d = 32'h78DF30EC;
            3'd4: d = 32'h715EA49E;
            3'd5: d = 32'hC785DA0A;
            3'd6: d = 32'hE04EF22A;
            default: d = 32'hE5C40957;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} << n;
        return w[63:32];
    endfunction
endpackage

>>> rtl/lea_block_cipher.sv
`timescale 1ns / 1ps
// LEA block cipher, 128-bit block, 128/192/256-bit keys.
// Configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready is high
// while idle and start is low. Indexes 0..3 hold the key, 4 the key size, 5
// the round count in groups of four (0 picks 24, 28 or 32). Any listed write
// marks the round keys stale.
// Blocks: pulse start with cmd, block_lo and block_hi while busy is low.
// The result appears on out_lo/out_hi for one cycle with done high; the
// receiver cannot stall it.
// Per block, the key store read is registered, so the first round key row is
// fetched before the rounds start; the rounds then run one round per cycle,
// and the result is shown in a separate done state. The next block is
// accepted only once the block is idle again after the result. The first
// block after reset or a listed configuration write first runs the key
// schedule, one round key row per cycle, before its rounds.
// Reset clears the key registers to zero and marks the round keys stale.
module lea_block_cipher #(
    parameter int unsigned MAX_ROUNDS = lea_pkg::MAX_ROUNDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [63:0]                   block_lo,
    input  logic [63:0]                   block_hi,
    output logic                          done,
    output logic [63:0]                   out_lo,
    output logic [63:0]                   out_hi
);
    import lea_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned LIMIT = (MAX_ROUNDS / 4) * 4;
    localparam int unsigned RW = $clog2(LIMIT + 1);
    localparam int unsigned AW = (LIMIT > 1) ? $clog2(LIMIT) : 1;

    lea_state_t state_reg, state_next;
    logic [255:0] key_reg;
    logic [1:0]   size_reg;
    logic [3:0]   groups_reg;
    logic         ready_reg, ready_next;
    logic [RW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] rounds;
    logic [5:0]   rounds_raw;
    logic         dec_reg, dec_next;
    logic [127:0] x_reg, x_next;
    logic         first_reg, first_next;
    logic         cfg_fire;
    logic         ks_load;
    logic         we;
    logic [AW-1:0] waddr, raddr;
    lea_rk_row_t  wrow, rrow;
    logic [127:0] y;

    // A block start takes precedence, so a key change never races a block.
    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        rounds_raw = {groups_reg, 2'b00};
        if (groups_reg == 4'd0)
        begin
            case (size_reg)
                KS_128: rounds_raw = 6'd24;
                KS_192: rounds_raw = 6'd28;
                default: rounds_raw = 6'd32;
            endcase
        end
        if (32'(rounds_raw) > LIMIT)
        begin
            rounds = RW'(LIMIT);
        end
        else
        begin
            rounds = RW'(rounds_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            size_reg <= '0;
            groups_reg <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_KEY0: key_reg[63:0] <= cfg_data;
                REG_KEY1: key_reg[127:64] <= cfg_data;
                REG_KEY2: key_reg[191:128] <= cfg_data;
                REG_KEY3: key_reg[255:192] <= cfg_data;
                REG_SIZE: size_reg <= cfg_data[1:0];
                REG_GROUPS: groups_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    lea_keysched u_ks (
        .clk(clk), .load(ks_load), .key(key_reg), .key_size(size_reg),
        .round_idx(5'(cnt_reg)), .row(wrow)
    );

    lea_rk_mem #(.DEPTH(LIMIT), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wrow), .raddr(raddr), .rdata(rrow)
    );

    lea_round u_round (.dec(dec_reg), .x(x_reg), .k(rrow), .y(y));

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        cnt_next = cnt_reg;
        dec_next = dec_reg;
        x_next = x_reg;
        first_next = 1'b0;
        ks_load = 1'b0;
        we = 1'b0;
        waddr = AW'(cnt_reg);
        raddr = '0;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ks_load = 1'b1;
                if (cfg_fire && cfg_index <= REG_GROUPS)
                begin
                    ready_next = 1'b0;
                end
                if (start)
                begin
                    dec_next = cmd;
                    x_next = {block_hi, block_lo};
                    cnt_next = '0;
                    if (ready_reg)
                    begin
                        state_next = ST_CRYPT;
                        first_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_EXPAND;
                    end
                end
            end
            ST_EXPAND:
            begin
                we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == rounds - 1'b1)
                begin
                    ready_next = 1'b1;
                    cnt_next = '0;
                    first_next = 1'b1;
                    state_next = ST_CRYPT;
                end
            end
            ST_CRYPT:
            begin
                // The row for the next round is fetched ahead through the registered read.
                if (dec_reg)
                begin
                    raddr = AW'(rounds - 1'b1 - (first_reg ? cnt_reg : cnt_reg + 1'b1));
                end
                else
                begin
                    raddr = AW'(first_reg ? cnt_reg : cnt_reg + 1'b1);
                end
                if (!first_reg)
                begin
                    x_next = y;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == rounds - 1'b1)
                    begin
                        cnt_next = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                done = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
            cnt_reg <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            cnt_reg <= cnt_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
        x_reg <= x_next;
    end

    assign out_lo = x_reg[63:0];
    assign out_hi = x_reg[127:64];

    `ASSERT_IMPLY(a_cfg_idle, clk, rst_n, cfg_ready, !busy, "config port open while busy")
    `ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy, "block not idle after result")
    `ASSERT_IMPLY(a_crypt_ready, clk, rst_n, state_reg == ST_CRYPT, ready_reg,
        "rounds run on stale keys")
    `ASSERT_IMPLY(a_cnt_bound, clk, rst_n, busy, cnt_reg < rounds, "round counter overrun")
endmodule

>>> rtl/lea_rk_mem.sv
`timescale 1ns / 1ps
module lea_rk_mem #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW = 5
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  lea_pkg::lea_rk_row_t wdata,
    input  logic [AW-1:0]       raddr,
    output lea_pkg::lea_rk_row_t rdata
);
    import lea_pkg::*;

    lea_rk_row_t mem [DEPTH];
    lea_rk_row_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/lea_keysched.sv
`timescale 1ns / 1ps
module lea_keysched (
    input  logic                 clk,
    input  logic                 load,
    input  logic [255:0]         key,
    input  logic [1:0]           key_size,
    input  logic [4:0]           round_idx,
    output lea_pkg::lea_rk_row_t row
);
    import lea_pkg::*;

    logic [31:0] t_reg [8];
    logic [31:0] t_next [8];
    logic [31:0] ci;
    logic [2:0]  ci_idx;
    logic [10:0] div6;
    logic [31:0] rk [6];
    logic [2:0]  p;
    logic [7:0]  base;

    localparam logic [4:0] ROTS [6] = '{5'd1, 5'd3, 5'd6, 5'd11, 5'd13, 5'd17};

    always_comb
    begin
        ci_idx = 3'd0;
        // The quotient by six comes from a reciprocal multiply, exact for indexes below 32.
        div6 = 11'(round_idx) * 11'd43;
        case (key_size)
            KS_128: ci_idx = {1'b0, round_idx[1:0]};
            KS_192: ci_idx = 3'(round_idx - 5'(div6[10:8]) * 5'd6);
            default: ci_idx = round_idx[2:0];
        endcase
        ci = delta(ci_idx);
        base = 8'(round_idx) * 8'd6;
        for (int i = 0; i < 8; i++)
        begin
            t_next[i] = t_reg[i];
        end
        for (int j = 0; j < 6; j++)
        begin
            rk[j] = '0;
        end
        p = 3'd0;
        case (key_size)
            KS_128:
            begin
                for (int j = 0; j < 4; j++)
                begin
                    t_next[j] = rol32(t_reg[j] + rol32(ci, round_idx + 5'(j)), ROTS[j]);
                end
                rk[0] = t_next[0];
                rk[1] = t_next[1];
                rk[2] = t_next[2];
                rk[3] = t_next[1];
                rk[4] = t_next[3];
                rk[5] = t_next[1];
            end
            KS_192:
            begin
                for (int j = 0; j < 6; j++)
                begin
                    t_next[j] = rol32(t_reg[j] + rol32(ci, round_idx + 5'(j)), ROTS[j]);
                    rk[j] = t_next[j];
                end
            end
            default:
            begin
                // Each round touches six of the eight words, cycling around.
                for (int j = 0; j < 6; j++)
                begin
                    p = 3'(base + 8'(j));
                    t_next[p] = rol32(t_reg[p] + rol32(ci, round_idx + 5'(j)), ROTS[j]);
                    rk[j] = t_next[p];
                end
            end
        endcase
        row = {rk[5], rk[4], rk[3], rk[2], rk[1], rk[0]};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            if (load)
            begin
                t_reg[i] <= key[32*i +: 32];
            end
            else
            begin
                t_reg[i] <= t_next[i];
            end
        end
    end
endmodule

>>> rtl/lea_round.sv
`timescale 1ns / 1ps
module lea_round (
    input  logic                 dec,
    input  logic [127:0]         x,
    input  lea_pkg::lea_rk_row_t k,
    output logic [127:0]         y
);
    import lea_pkg::*;

    logic [31:0] x0, x1, x2, x3, k0, k1, k2, k3, k4, k5;
    logic [31:0] n0, n1, n2, p1, p2, p3;

    always_comb
    begin
        {x3, x2, x1, x0} = x;
        {k5, k4, k3, k2, k1, k0} = k;
        n0 = rol32((x0 ^ k0) + (x1 ^ k1), 5'd9);
        n1 = rol32((x1 ^ k2) + (x2 ^ k3), 5'd27);
        n2 = rol32((x2 ^ k4) + (x3 ^ k5), 5'd29);
        p1 = (rol32(x0, 5'd23) - (x3 ^ k0)) ^ k1;
        p2 = (rol32(x1, 5'd5) - (p1 ^ k2)) ^ k3;
        p3 = (rol32(x2, 5'd3) - (p2 ^ k4)) ^ k5;
        if (dec)
        begin
            y = {p3, p2, p1, x3};
        end
        else
        begin
            y = {x0, n2, n1, n0};
        end
    end
endmodule
